@@ src/bubble_sorter_top_macros.svh @@
// ----------------------------------------------------------------------------
// bubble_sorter_top_macros.svh
// Assertion macros shared by the sorter RTL files.
// ----------------------------------------------------------------------------
`ifndef BUBBLE_SORTER_TOP_MACROS_SVH
`define BUBBLE_SORTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BSORT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BSORT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/bsort_pkg.sv @@
// ----------------------------------------------------------------------------
// bsort_pkg
// Shared types and constants for the systolic sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package bsort_pkg;

	localparam int DATA_W           = 32;
	localparam int MAX_ELEMENTS_DEF = 64;

	typedef logic signed [DATA_W-1:0] elem_t;

	// What every cell does in a given cycle
	typedef enum logic [1:0] {
		CELL_INSERT,   // take the incoming element, pass the larger one on
		CELL_SHIFT_LO, // move contents one cell toward cell 0
		CELL_SHIFT_HI  // move contents one cell toward the far end
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t mode;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/bsort_cell.sv @@
// ----------------------------------------------------------------------------
// bsort_cell
// One compare-exchange cell: keeps the smallest element it has seen and
// hands the other one on to the next cell through a register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bubble_sorter_top_macros.svh"

module bsort_cell import bsort_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctrl_t ctrl,
	// element handed in from the previous cell
	input  wire logic       ins_vld,
	input  wire elem_t      ins_val,
	// held contents of the neighbors
	input  wire logic       lo_vld,
	input  wire elem_t      lo_val,
	input  wire logic       hi_vld,
	input  wire elem_t      hi_val,
	// this cell's state
	output logic            held_vld,
	output elem_t           held_val,
	output logic            pass_vld,
	output elem_t           pass_val
);

	logic  held_vld_q;
	elem_t held_val_q;
	logic  pass_vld_q;
	elem_t pass_val_q;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_vld_q <= 1'b0;
			pass_vld_q <= 1'b0;
		end else begin
			case (ctrl.mode)
				CELL_INSERT: begin
					if (ins_vld) begin
						held_vld_q <= 1'b1;
						pass_vld_q <= held_vld_q;
					end else begin
						pass_vld_q <= 1'b0;
					end
				end
				CELL_SHIFT_LO: begin
					held_vld_q <= hi_vld;
					pass_vld_q <= 1'b0;
				end
				CELL_SHIFT_HI: begin
					held_vld_q <= lo_vld;
					pass_vld_q <= 1'b0;
				end
				default: begin
					pass_vld_q <= 1'b0;
				end
			endcase
		end
	end

	// data: keep the smaller of held and incoming, pass the other
	always_ff @(posedge clk) begin
		case (ctrl.mode)
			CELL_INSERT: begin
				if (ins_vld) begin
					if (!held_vld_q) begin
						held_val_q <= ins_val;
					end else if (ins_val < held_val_q) begin
						held_val_q <= ins_val;
						pass_val_q <= held_val_q;
					end else begin
						pass_val_q <= ins_val;
					end
				end
			end
			CELL_SHIFT_LO: begin
				held_val_q <= hi_val;
			end
			CELL_SHIFT_HI: begin
				held_val_q <= lo_val;
			end
			default: begin
				held_val_q <= held_val_q;
			end
		endcase
	end

	assign held_vld = held_vld_q;
	assign held_val = held_val_q;
	assign pass_vld = pass_vld_q;
	assign pass_val = pass_val_q;

	// an empty cell never has anything in flight to its neighbor
	`BSORT_ASSERT_IMP(a_pass_needs_held, clk, arst_n, pass_vld_q, held_vld_q,
		"cell passes an element while empty")

endmodule

`default_nettype wire

@@ src/bubble_sorter_top.sv @@
// ----------------------------------------------------------------------------
// bubble_sorter_top
// Sorts a list of signed 32-bit elements in a chain of compare-exchange
// cells and plays the sorted list back in ascending or descending order.
//
//   channel   signals                                   direction
//   request   start, busy, element_value, last_element  in (busy is out)
//   result    result_valid, sorted_value, last_result,  out
//             overflow
//   config    cfg_valid, cfg_ready, cfg_data             in (cfg_ready is out)
//
// Loading takes one element per cycle; busy stays low until the last one.
// After the last element the chain settles in the drain state, then
// emits one result per cycle once the head of the list reaches the
// read end: cell 0 ascending, the far end of the chain descending.
// Reset empties the chain and clears the count and the overflow flag.
// The receiver cannot stall; results are strobed for one cycle each.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bubble_sorter_top_macros.svh"

module bubble_sorter_top import bsort_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// request channel
	input  wire logic              start,
	output logic                   busy,
	input  wire logic signed [31:0] element_value,
	input  wire logic              last_element,
	// result channel
	output logic                   result_valid,
	output logic signed [31:0]     sorted_value,
	output logic                   last_result,
	output logic                   overflow,
	// configuration channel
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_data
);

	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam int DRN_W = $clog2(MAX_ELEMENTS);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] emit_cnt_q;
	logic [DRN_W-1:0] drain_cnt_q;
	logic             ovf_q;
	logic             desc_q;
	logic             result_valid_q;
	elem_t            sorted_value_q;
	logic             last_result_q;
	logic             overflow_q;

	logic             accept;
	logic             store_full;
	logic             src_vld;
	elem_t            src_val;
	logic             emit_last;
	cell_ctrl_t       cell_ctrl;

	logic  held_vld [MAX_ELEMENTS];
	elem_t held_val [MAX_ELEMENTS];
	logic  pass_vld [MAX_ELEMENTS];
	elem_t pass_val [MAX_ELEMENTS];

	assign busy       = (state_q != ST_LOAD);
	assign accept     = start && !busy;
	assign store_full = (count_q == CNT_W'(MAX_ELEMENTS));
	assign cfg_ready  = 1'b1;

	// chain control: insert while loading and settling, shift while emitting
	always_comb begin
		cell_ctrl.mode = CELL_INSERT;
		if (state_q == ST_EMIT) begin
			cell_ctrl.mode = desc_q ? CELL_SHIFT_HI : CELL_SHIFT_LO;
		end
	end

	// ascending lists leave from cell 0, descending from the far end
	assign src_vld   = desc_q ? held_vld[MAX_ELEMENTS-1] : held_vld[0];
	assign src_val   = desc_q ? held_val[MAX_ELEMENTS-1] : held_val[0];
	assign emit_last = (emit_cnt_q + CNT_W'(1)) == count_q;

	// cell chain
	for (genvar gi = 0; gi < MAX_ELEMENTS; gi++) begin : g_cell
		logic  c_ins_vld;
		elem_t c_ins_val;
		logic  c_lo_vld;
		elem_t c_lo_val;
		logic  c_hi_vld;
		elem_t c_hi_val;

		if (gi == 0) begin : g_first
			assign c_ins_vld = accept && !store_full;
			assign c_ins_val = element_value;
			assign c_lo_vld  = 1'b0;
			assign c_lo_val  = '0;
		end else begin : g_mid
			assign c_ins_vld = pass_vld[gi-1];
			assign c_ins_val = pass_val[gi-1];
			assign c_lo_vld  = held_vld[gi-1];
			assign c_lo_val  = held_val[gi-1];
		end

		if (gi == MAX_ELEMENTS - 1) begin : g_end
			assign c_hi_vld = 1'b0;
			assign c_hi_val = '0;
		end else begin : g_inner
			assign c_hi_vld = held_vld[gi+1];
			assign c_hi_val = held_val[gi+1];
		end

		bsort_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cell_ctrl),
			.ins_vld  (c_ins_vld),
			.ins_val  (c_ins_val),
			.lo_vld   (c_lo_vld),
			.lo_val   (c_lo_val),
			.hi_vld   (c_hi_vld),
			.hi_val   (c_hi_val),
			.held_vld (held_vld[gi]),
			.held_val (held_val[gi]),
			.pass_vld (pass_vld[gi]),
			.pass_val (pass_val[gi])
		);
	end

	// sequencer state, list bookkeeping and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			count_q        <= '0;
			emit_cnt_q     <= '0;
			drain_cnt_q    <= '0;
			ovf_q          <= 1'b0;
			desc_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				desc_q <= cfg_data;
			end
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (store_full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
						if (last_element) begin
							drain_cnt_q <= '0;
							state_q     <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					drain_cnt_q <= drain_cnt_q + DRN_W'(1);
					if (drain_cnt_q == DRN_W'(MAX_ELEMENTS - 1)) begin
						emit_cnt_q <= '0;
						state_q    <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (src_vld) begin
						result_valid_q <= 1'b1;
						emit_cnt_q     <= emit_cnt_q + CNT_W'(1);
						if (emit_last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && src_vld) begin
			sorted_value_q <= src_val;
			last_result_q  <= emit_last;
			overflow_q     <= ovf_q;
		end
	end

	assign result_valid = result_valid_q;
	assign sorted_value = sorted_value_q;
	assign last_result  = last_result_q;
	assign overflow     = overflow_q;

	`BSORT_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_ELEMENTS),
		"element count beyond capacity")
	`BSORT_ASSERT_IMP(a_ovf_only_full, clk, arst_n, ovf_q, store_full,
		"overflow flagged with room left")
	`BSORT_ASSERT_NXT(a_no_result_loading, clk, arst_n, state_q == ST_LOAD, !result_valid,
		"result strobed without a sort running")
	`BSORT_ASSERT_NXT(a_last_ends_list, clk, arst_n, result_valid && last_result,
		!result_valid, "results continue after the last one")

endmodule

`default_nettype wire
